// ===== src/srsw_pkg.sv =====
// Package for the selective-repeat sender window: field widths, command and
// result codes, the controller/datapath handshake structs and slot helpers.
// No dependencies.
`default_nettype none

package srsw_pkg;

   localparam int WINDOW_SIZE  = 8;
   localparam int SLOT_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int SEQ_W        = 32;
   localparam int CMD_W        = 2;
   localparam int KIND_W       = 3;
   localparam int SLOT_FIELD_W = 5;
   localparam int TIMER_W      = 2;
   localparam int COUNT_W      = 8;
   localparam logic [COUNT_W-1:0] MAX_TIMEOUTS_RESET = COUNT_W'(3);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [SEQ_W-1:0]  seq_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_SEND    = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SENT      = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_ACK       = 3'd2,
      KIND_RESTART   = 3'd3,
      KIND_RETRANSMIT = 3'd4,
      KIND_GAVE_UP   = 3'd5,
      KIND_CLOSED    = 3'd6
   } kind_type;

   typedef enum logic [TIMER_W-1:0] {
      TMR_NONE  = 2'd0,
      TMR_START = 2'd1,
      TMR_STOP  = 2'd2
   } timer_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_STAGE_CLOSED,
      OP_SEND,
      OP_ACK_MARK,
      OP_ADV_START,
      OP_ADV_STEP,
      OP_ADV_DONE,
      OP_TIMEOUT,
      OP_RTX_SKIP,
      OP_RTX_STAGE
   } op_type;

   typedef struct packed {
      logic   capture;  // latch the accepted request
      op_type op;
      logic   emit;     // load the staged result into the output register
      logic   last;
   } ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    closed;
      logic    base_hit;   // ack equals base of a non-empty window
      logic    give_up;    // this timeout exceeds the limit
      logic    scan_end;   // scan pointer reached next_seq
      logic    scan_acked; // slot under the scan pointer is acknowledged
      logic    out_free;   // output register can take a result
   } stat_type;

   // Advance a slot index with wrap at the window size
   function automatic slot_type slot_inc(slot_type s);
      slot_type r;
      if (s == SLOT_W'(WINDOW_SIZE - 1)) r = '0;
      else                                r = s + SLOT_W'(1);
      return r;
   endfunction

   // Slot of a sequence number lying off slots ahead of a base slot
   function automatic slot_type slot_add(slot_type s, slot_type off);
      logic [SLOT_W:0] sum;
      sum = {1'b0, s} + {1'b0, off};
      if (sum >= (SLOT_W + 1)'(WINDOW_SIZE)) sum = sum - (SLOT_W + 1)'(WINDOW_SIZE);
      return sum[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/srsw_req_if.sv =====
// Request channel of the sender window: valid/ready with command payload.
// Depends on srsw_pkg.
`default_nettype none

interface srsw_req_if;
   logic                        valid;
   logic                        ready;
   logic [srsw_pkg::CMD_W-1:0]  command;
   logic [srsw_pkg::SEQ_W-1:0]  ack_seq;

   modport source (output valid, output command, output ack_seq, input ready);
   modport sink   (input valid, input command, input ack_seq, output ready);
endinterface

`default_nettype wire

// ===== src/srsw_rsp_if.sv =====
// Response channel of the sender window: valid/ready with result payload.
// Depends on srsw_pkg.
`default_nettype none

interface srsw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [srsw_pkg::KIND_W-1:0]       kind;
   logic [srsw_pkg::SEQ_W-1:0]        seq;
   logic [srsw_pkg::SLOT_FIELD_W-1:0] slot;
   logic [srsw_pkg::TIMER_W-1:0]      timer_action;
   logic [srsw_pkg::SEQ_W-1:0]        window_base;
   logic                              last;

   modport source (output valid, output kind, output seq, output slot,
                   output timer_action, output window_base, output last, input ready);
   modport sink   (input valid, input kind, input seq, input slot,
                   input timer_action, input window_base, input last, output ready);
endinterface

`default_nettype wire

// ===== src/selective_repeat_sender_window_top.sv =====
// Top level of the selective-repeat sender window: controller plus datapath.
// Depends on srsw_pkg, srsw_req_if, srsw_rsp_if, srsw_ctrl and srsw_dp.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+--------------------------------
//   req_chan  | in        | valid/ready        | command, ack_seq
//   rsp_chan  | out       | valid/ready        | kind, seq, slot, timer_action,
//             |           |                    | window_base, last
//   csr_*     | in        | csr_wr_en          | csr_wr_data (max_timeouts)
//
// Sequence: a send, a plain ack, a give-up or a closed-state command passes through
// accept, execute and emit; an unused command is accepted and executed and yields
// nothing. An ack of the base then walks the base past each acknowledged slot in
// turn. A timeout that retransmits then scans every slot in the window from the
// base, with the single scan pointer over the slot bits.
// Reset is synchronous; no clearing pass is needed. The output register frees
// the request side, so the next transaction is accepted while a result waits; a
// stalled result channel holds the controller in its retransmit or emit step.
`default_nettype none

module selective_repeat_sender_window_top (
   input  logic                                clock,
   input  logic                                reset,
   srsw_req_if.sink                            req_chan,
   srsw_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [srsw_pkg::COUNT_W-1:0]        csr_wr_data
);
   import srsw_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   // Controller: one transaction at a time, walks scans slot by slot
   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // Datapath: window state, slot bits and the result register
   srsw_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_command      (req_chan.command),
      .req_ack_seq      (req_chan.ack_seq),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_kind         (rsp_chan.kind),
      .rsp_seq          (rsp_chan.seq),
      .rsp_slot         (rsp_chan.slot),
      .rsp_timer_action (rsp_chan.timer_action),
      .rsp_window_base  (rsp_chan.window_base),
      .rsp_last         (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ===== src/srsw_ctrl.sv =====
// Controller state machine of the sender window: sequences each command
// through the datapath. Depends on srsw_pkg.
`default_nettype none

module srsw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  srsw_pkg::stat_type stat,
   output srsw_pkg::ctrl_type ctrl
);
   import srsw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADV,
      ST_RTX,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ctrl.capture = 1'b0;
      ctrl.op      = OP_NONE;
      ctrl.emit    = 1'b0;
      ctrl.last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.cmd == CMD_NONE) begin
               state_in = ST_IDLE;
            end else if (stat.closed) begin
               ctrl.op  = OP_STAGE_CLOSED;
               state_in = ST_EMIT;
            end else begin
               unique case (stat.cmd)
                  CMD_SEND: begin
                     ctrl.op  = OP_SEND;
                     state_in = ST_EMIT;
                  end
                  CMD_ACK: begin
                     if (stat.base_hit) begin
                        ctrl.op  = OP_ADV_START;
                        state_in = ST_ADV;
                     end else begin
                        ctrl.op  = OP_ACK_MARK;
                        state_in = ST_EMIT;
                     end
                  end
                  CMD_TIMEOUT: begin
                     ctrl.op  = OP_TIMEOUT;
                     state_in = stat.give_up ? ST_EMIT : ST_RTX;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADV: begin
            // Slide past acknowledged slots, then commit the new base
            if (!stat.scan_end && stat.scan_acked) begin
               ctrl.op = OP_ADV_STEP;
            end else begin
               ctrl.op  = OP_ADV_DONE;
               state_in = ST_EMIT;
            end
         end
         ST_RTX: begin
            // Release the staged result once the next one is found
            if (stat.scan_end) begin
               state_in = ST_EMIT;
            end else if (stat.scan_acked) begin
               ctrl.op = OP_RTX_SKIP;
            end else if (stat.out_free) begin
               ctrl.emit = 1'b1;
               ctrl.op   = OP_RTX_STAGE;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               ctrl.emit = 1'b1;
               ctrl.last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== src/srsw_dp.sv =====
// Datapath of the sender window: sequence and slot registers, acknowledged
// bits, timeout count, scan pointer and the output register. Depends on srsw_pkg.
`default_nettype none

module srsw_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  srsw_pkg::ctrl_type                 ctrl,
   output srsw_pkg::stat_type                 stat,
   input  logic [srsw_pkg::CMD_W-1:0]         req_command,
   input  logic [srsw_pkg::SEQ_W-1:0]         req_ack_seq,
   input  logic                               csr_wr_en,
   input  logic [srsw_pkg::COUNT_W-1:0]       csr_wr_data,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [srsw_pkg::KIND_W-1:0]        rsp_kind,
   output logic [srsw_pkg::SEQ_W-1:0]         rsp_seq,
   output logic [srsw_pkg::SLOT_FIELD_W-1:0]  rsp_slot,
   output logic [srsw_pkg::TIMER_W-1:0]       rsp_timer_action,
   output logic [srsw_pkg::SEQ_W-1:0]         rsp_window_base,
   output logic                               rsp_last
);
   import srsw_pkg::*;

   // Control state
   seq_type                 base_ff, base_in, next_ff, next_in;
   slot_type                base_slot_ff, base_slot_in, next_slot_ff, next_slot_in;
   logic [COUNT_W-1:0]      tcount_ff, tcount_in, max_to_ff, max_to_in;
   logic                    closed_ff, closed_in, out_valid_ff, out_valid_in;
   // Payload state
   cmd_type                 cmd_ff, cmd_in;
   seq_type                 ack_ff, ack_in, ptr_ff, ptr_in;
   slot_type                ptr_slot_ff, ptr_slot_in;
   logic [WINDOW_SIZE-1:0]  acked_ff, acked_in;
   kind_type                stage_kind_ff, stage_kind_in;
   seq_type                 stage_seq_ff, stage_seq_in;
   slot_type                stage_slot_ff, stage_slot_in;
   timer_type               stage_timer_ff, stage_timer_in;
   kind_type                out_kind_ff, out_kind_in;
   seq_type                 out_seq_ff, out_seq_in, out_base_ff, out_base_in;
   slot_type                out_slot_ff, out_slot_in;
   timer_type               out_timer_ff, out_timer_in;
   logic                    out_last_ff, out_last_in;

   seq_type                 used, ack_diff;
   logic                    full, in_window;
   slot_type                mark_slot;
   logic [COUNT_W-1:0]      tcount_inc;

   assign used       = next_ff - base_ff;
   assign full       = (used >= SEQ_W'(WINDOW_SIZE));
   assign ack_diff   = ack_ff - base_ff;
   assign in_window  = (ack_diff != '0) && (ack_diff < used);
   assign mark_slot  = slot_add(base_slot_ff, ack_diff[SLOT_W-1:0]);
   assign tcount_inc = (tcount_ff == '1) ? tcount_ff : tcount_ff + COUNT_W'(1);

   assign stat.cmd        = cmd_ff;
   assign stat.closed     = closed_ff;
   assign stat.base_hit   = (ack_ff == base_ff) && (used != '0);
   assign stat.give_up    = (tcount_inc > max_to_ff);
   assign stat.scan_end   = (ptr_ff == next_ff);
   assign stat.scan_acked = acked_ff[ptr_slot_ff];
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      base_in        = base_ff;
      next_in        = next_ff;
      base_slot_in   = base_slot_ff;
      next_slot_in   = next_slot_ff;
      tcount_in      = tcount_ff;
      max_to_in      = max_to_ff;
      closed_in      = closed_ff;
      cmd_in         = cmd_ff;
      ack_in         = ack_ff;
      ptr_in         = ptr_ff;
      ptr_slot_in    = ptr_slot_ff;
      acked_in       = acked_ff;
      stage_kind_in  = stage_kind_ff;
      stage_seq_in   = stage_seq_ff;
      stage_slot_in  = stage_slot_ff;
      stage_timer_in = stage_timer_ff;
      out_kind_in    = out_kind_ff;
      out_seq_in     = out_seq_ff;
      out_slot_in    = out_slot_ff;
      out_timer_in   = out_timer_ff;
      out_base_in    = out_base_ff;
      out_last_in    = out_last_ff;
      out_valid_in   = out_valid_ff;

      if (ctrl.capture) begin
         cmd_in = cmd_type'(req_command);
         ack_in = req_ack_seq;
      end
      if (csr_wr_en) max_to_in = csr_wr_data;

      case (ctrl.op)
         OP_STAGE_CLOSED: begin
            stage_kind_in  = KIND_CLOSED;
            stage_seq_in   = '0;
            stage_slot_in  = '0;
            stage_timer_in = TMR_NONE;
         end
         OP_SEND: begin
            if (!full) begin
               acked_in[next_slot_ff] = 1'b0;
               next_in        = next_ff + SEQ_W'(1);
               next_slot_in   = slot_inc(next_slot_ff);
               stage_kind_in  = KIND_SENT;
               stage_seq_in   = next_ff;
               stage_slot_in  = next_slot_ff;
               stage_timer_in = (used == '0) ? TMR_START : TMR_NONE;
            end else begin
               stage_kind_in  = KIND_FULL;
               stage_seq_in   = '0;
               stage_slot_in  = '0;
               stage_timer_in = TMR_NONE;
            end
         end
         OP_ACK_MARK: begin
            if (in_window) acked_in[mark_slot] = 1'b1;
            stage_kind_in  = KIND_ACK;
            stage_seq_in   = '0;
            stage_slot_in  = '0;
            stage_timer_in = TMR_NONE;
         end
         OP_ADV_START: begin
            ptr_in      = base_ff + SEQ_W'(1);
            ptr_slot_in = slot_inc(base_slot_ff);
         end
         OP_ADV_STEP, OP_RTX_SKIP: begin
            ptr_in      = ptr_ff + SEQ_W'(1);
            ptr_slot_in = slot_inc(ptr_slot_ff);
         end
         OP_ADV_DONE: begin
            base_in        = ptr_ff;
            base_slot_in   = ptr_slot_ff;
            stage_kind_in  = KIND_ACK;
            stage_seq_in   = '0;
            stage_slot_in  = '0;
            stage_timer_in = (ptr_ff == next_ff) ? TMR_STOP : TMR_START;
         end
         OP_TIMEOUT: begin
            tcount_in      = tcount_inc;
            stage_seq_in   = '0;
            stage_slot_in  = '0;
            ptr_in         = base_ff;
            ptr_slot_in    = base_slot_ff;
            if (stat.give_up) begin
               closed_in      = 1'b1;
               stage_kind_in  = KIND_GAVE_UP;
               stage_timer_in = TMR_STOP;
            end else begin
               stage_kind_in  = KIND_RESTART;
               stage_timer_in = TMR_START;
            end
         end
         OP_RTX_STAGE: begin
            stage_kind_in  = KIND_RETRANSMIT;
            stage_seq_in   = ptr_ff;
            stage_slot_in  = ptr_slot_ff;
            stage_timer_in = TMR_NONE;
            ptr_in         = ptr_ff + SEQ_W'(1);
            ptr_slot_in    = slot_inc(ptr_slot_ff);
         end
         default: ;
      endcase

      // Output register: load on emit, drop when taken
      if (ctrl.emit) begin
         out_kind_in  = stage_kind_ff;
         out_seq_in   = stage_seq_ff;
         out_slot_in  = stage_slot_ff;
         out_timer_in = stage_timer_ff;
         out_base_in  = base_ff;
         out_last_in  = ctrl.last;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
         tcount_ff    <= '0;
         max_to_ff    <= MAX_TIMEOUTS_RESET;
         closed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         tcount_ff    <= tcount_in;
         max_to_ff    <= max_to_in;
         closed_ff    <= closed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      ack_ff         <= ack_in;
      ptr_ff         <= ptr_in;
      ptr_slot_ff    <= ptr_slot_in;
      acked_ff       <= acked_in;
      stage_kind_ff  <= stage_kind_in;
      stage_seq_ff   <= stage_seq_in;
      stage_slot_ff  <= stage_slot_in;
      stage_timer_ff <= stage_timer_in;
      out_kind_ff    <= out_kind_in;
      out_seq_ff     <= out_seq_in;
      out_slot_ff    <= out_slot_in;
      out_timer_ff   <= out_timer_in;
      out_base_ff    <= out_base_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_seq          = out_seq_ff;
   assign rsp_slot         = SLOT_FIELD_W'(out_slot_ff);
   assign rsp_timer_action = out_timer_ff;
   assign rsp_window_base  = out_base_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// ===== src/srsw_checker.sv =====
// Port-level checker for the sender window and its bind to the top level.
// Depends on srsw_pkg.
`default_nettype none

module srsw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [srsw_pkg::KIND_W-1:0]        rsp_kind,
   input logic [srsw_pkg::SEQ_W-1:0]         rsp_seq,
   input logic [srsw_pkg::SLOT_FIELD_W-1:0]  rsp_slot,
   input logic [srsw_pkg::TIMER_W-1:0]       rsp_timer_action,
   input logic                               rsp_last
);
   import srsw_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_seq)
         && $stable(rsp_last))
      else $error("stalled result changed");

   // Single-result transactions always close themselves
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SENT || rsp_kind == KIND_FULL || rsp_kind == KIND_ACK
         || rsp_kind == KIND_GAVE_UP || rsp_kind == KIND_CLOSED) |-> rsp_last)
      else $error("single result without last");

   // Only sent and retransmitted packets carry a sequence and slot
   a_seq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SENT && rsp_kind != KIND_RETRANSMIT
         |-> rsp_seq == '0 && rsp_slot == '0)
      else $error("sequence on a non-packet result");

   // A timer restart starts the timer, a give-up stops it
   a_timer_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RESTART || rsp_kind == KIND_GAVE_UP)
         |-> (rsp_kind == KIND_RESTART && rsp_timer_action == TMR_START)
          || (rsp_kind == KIND_GAVE_UP && rsp_timer_action == TMR_STOP))
      else $error("timer action does not match result");

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_seq          (rsp_chan.seq),
   .rsp_slot         (rsp_chan.slot),
   .rsp_timer_action (rsp_chan.timer_action),
   .rsp_last         (rsp_chan.last)
);

`default_nettype wire
